// ===== rtl/core/sefr_pkg.sv =====
// Package for the STX/ETX frame receiver: character codes, result kinds
// and the receiver state record. No dependencies.
package sefr_pkg;

	localparam logic [7:0] CH_STX     = 8'd2;
	localparam logic [7:0] CH_ETX     = 8'd3;
	localparam logic [7:0] CH_ESC     = 8'd27;
	localparam logic [7:0] ESC_OFFSET = 8'h80;
	localparam logic [7:0] MAX_LENGTH_RESET = 8'd100;

	typedef enum logic [2:0] {
		KIND_DATA     = 3'd0,
		KIND_GOOD     = 3'd1,
		KIND_MISMATCH = 3'd2,
		KIND_OVERFLOW = 3'd3,
		KIND_RESTART  = 3'd4
	} kind_t;

	typedef struct packed {
		logic       hunting;
		logic       escape_pending;
		logic [7:0] write_index;
		logic [7:0] expected_length;
	} rx_state_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
	} result_t;

endpackage

// ===== rtl/core/sefr_decode.sv =====
// Per-byte decision logic of the frame receiver: next state and result.
// Depends on sefr_pkg.
module sefr_decode import sefr_pkg::*; (
	input  rx_state_t  state,
	input  logic [7:0] rx_byte,
	input  logic       rx_error,
	input  logic [7:0] max_length,
	output rx_state_t  state_next,
	output logic       res_valid,
	output result_t    res
);

	logic [7:0] unescaped;
	logic [7:0] len_base;
	logic [8:0] count;

	always_comb begin
		unescaped = state.escape_pending ? (rx_byte - ESC_OFFSET) : rx_byte;
		len_base = (state.write_index == 8'd0) ? unescaped : state.expected_length;
		count = {1'b0, state.write_index} + 9'd1;

		state_next = state;
		res_valid = 1'b0;
		res.kind = KIND_DATA;
		res.data_byte = 8'd0;
		res.byte_index = state.write_index;

		if (rx_error) begin
			state_next.hunting = 1'b1;
			state_next.escape_pending = 1'b0;
			state_next.write_index = 8'd0;
		end else if (state.hunting) begin
			if (rx_byte == CH_STX) begin
				state_next.hunting = 1'b0;
				state_next.escape_pending = 1'b0;
				state_next.write_index = 8'd0;
			end
		end else if (rx_byte == CH_STX) begin
			res_valid = 1'b1;
			res.kind = KIND_RESTART;
			state_next.write_index = 8'd0;
			state_next.escape_pending = 1'b0;
		end else if (rx_byte == CH_ESC) begin
			state_next.escape_pending = 1'b1;
		end else if (rx_byte == CH_ETX) begin
			res_valid = 1'b1;
			res.kind = (state.write_index != 8'd0 && state.expected_length == state.write_index)
				? KIND_GOOD : KIND_MISMATCH;
			state_next.hunting = 1'b1;
			state_next.escape_pending = 1'b0;
			state_next.write_index = 8'd0;
		end else begin
			// The length byte is taken from byte 0 and lowered once per escape.
			state_next.expected_length = state.escape_pending ? (len_base - 8'd1) : len_base;
			state_next.escape_pending = 1'b0;
			res_valid = 1'b1;
			if (count >= {1'b0, max_length}) begin
				res.kind = KIND_OVERFLOW;
				state_next.hunting = 1'b1;
				state_next.write_index = 8'd0;
			end else begin
				res.kind = KIND_DATA;
				res.data_byte = unescaped;
				state_next.write_index = count[7:0];
			end
		end
	end

endmodule

// ===== rtl/core/stx_etx_frame_receiver_core.sv =====
// Top level of the STX/ETX byte-stuffing frame receiver.
// Depends on sefr_pkg and sefr_decode.
// Path: a taken byte is held in the byte register, decoded, and its result is registered for the master side.
// Throughput: one byte per cycle; the byte register and the result register
// each advance whenever the result register is empty or being drained.
// Reset: asynchronous on arst_n; the receiver hunts for STX and max_length is 100.
module stx_etx_frame_receiver_core import sefr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] rx_error
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] data_byte, [15:8] byte_index
	output logic [2:0]  m_tuser    // [2:0] kind
);

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       rx_error_s1;
	logic [7:0] max_length_q;
	rx_state_t  state_q;
	rx_state_t  state_next;
	logic       res_valid;
	result_t    res;
	result_t    res_q;
	logic       out_valid_q;
	logic       out_free;
	logic       advance;
	logic       res_load;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign res_load = advance && res_valid;
	assign s_tready = !valid_s1 || out_free;

	sefr_decode u_decode (
		.state      (state_q),
		.rx_byte    (rx_byte_s1),
		.rx_error   (rx_error_s1),
		.max_length (max_length_q),
		.state_next (state_next),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RESET;
		end else if (cfg_we) begin
			max_length_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			rx_byte_s1  <= s_tdata;
			rx_error_s1 <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.hunting         <= 1'b1;
			state_q.escape_pending  <= 1'b0;
			state_q.write_index     <= 8'd0;
			state_q.expected_length <= 8'd0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {res_q.byte_index, res_q.data_byte};
	assign m_tuser  = res_q.kind;

`ifndef SYNTHESIS
	a_hunt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.hunting |-> (state_q.write_index == 8'd0 && !state_q.escape_pending))
		else $error("hunting with a stale index or escape flag");

	a_end_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && (res.kind == KIND_GOOD || res.kind == KIND_MISMATCH ||
			res.kind == KIND_OVERFLOW)) |=> state_q.hunting)
		else $error("frame end did not return to hunting");

	a_data_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(res_load && res.kind == KIND_DATA) |=>
			(state_q.write_index == $past(res.byte_index) + 8'd1))
		else $error("data byte did not advance the index");

	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !advance)
		else $error("item decided while the result register is blocked");
`endif

endmodule

// ===== tb/stx_etx_frame_receiver_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for stx_etx_frame_receiver_core: framed byte streams with
// escapes, line errors, restarts and overflows under random stalls on both sides.
// Depends on sefr_pkg and the receiver RTL.
module stx_etx_frame_receiver_core_tb;
	import sefr_pkg::*;

	class frame_scoreboard;
		bit         hunting = 1'b1;
		bit         esc_pending = 1'b0;
		logic [7:0] widx = 8'd0;
		logic [7:0] exp_len = 8'd0;
		logic [7:0] max_len = MAX_LENGTH_RESET;
		result_t    result_q[$];
		int         errors = 0;
		int         kind_seen[5];

		function int pending();
			return result_q.size();
		endfunction

		function void push_result(kind_t k, logic [7:0] d, logic [7:0] i);
			result_t r;
			r.kind = k;
			r.data_byte = d;
			r.byte_index = i;
			result_q.push_back(r);
		endfunction

		function void go_hunt();
			hunting = 1'b1;
			esc_pending = 1'b0;
			widx = 8'd0;
		endfunction

		// Advances the receiver state for one accepted request.
		function void note_request(logic [7:0] rx_byte, logic rx_error);
			logic [7:0] b;
			logic [7:0] idx;
			logic [8:0] cnt;
			bit         good;
			b = rx_byte;
			if (rx_error) begin
				go_hunt();
				return;
			end
			if (hunting) begin
				if (b == CH_STX) begin
					hunting = 1'b0;
					esc_pending = 1'b0;
					widx = 8'd0;
				end
				return;
			end
			if (b == CH_STX) begin
				push_result(KIND_RESTART, 8'd0, widx);
				widx = 8'd0;
				esc_pending = 1'b0;
				return;
			end
			if (b == CH_ESC) begin
				esc_pending = 1'b1;
				return;
			end
			if (b == CH_ETX) begin
				good = (widx != 8'd0) && (exp_len == widx);
				push_result(good ? KIND_GOOD : KIND_MISMATCH, 8'd0, widx);
				go_hunt();
				return;
			end
			idx = widx;
			if (idx == 8'd0) begin
				exp_len = b;
			end
			if (esc_pending) begin
				b = b - ESC_OFFSET;
				if (idx == 8'd0) begin
					exp_len = b;
				end
				exp_len = exp_len - 8'd1;
				esc_pending = 1'b0;
			end
			cnt = {1'b0, idx} + 9'd1;
			if (cnt >= {1'b0, max_len}) begin
				go_hunt();
				push_result(KIND_OVERFLOW, 8'd0, idx);
				return;
			end
			widx = cnt[7:0];
			push_result(KIND_DATA, b, idx);
		endfunction

		function void check_result(logic [2:0] kind, logic [15:0] tdata);
			result_t e;
			if (result_q.size() == 0) begin
				$error("unexpected result: kind %0d data_byte %0d byte_index %0d",
					kind, tdata[7:0], tdata[15:8]);
				errors++;
				return;
			end
			e = result_q.pop_front();
			if (kind !== e.kind) begin
				$error("kind: expected %0d, actual %0d", e.kind, kind);
				errors++;
			end
			if (tdata[7:0] !== e.data_byte) begin
				$error("data_byte: expected %0d, actual %0d", e.data_byte, tdata[7:0]);
				errors++;
			end
			if (tdata[15:8] !== e.byte_index) begin
				$error("byte_index: expected %0d, actual %0d", e.byte_index, tdata[15:8]);
				errors++;
			end
			if (kind < 3'd5) begin
				kind_seen[kind]++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] rx_byte
	logic        s_tuser;   // [0] rx_error
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [7:0] data_byte, [15:8] byte_index
	logic [2:0]  m_tuser;   // [2:0] kind

	frame_scoreboard sb;
	int          requests_sent = 0;
	int          counted_requests = 0;
	bit          counting = 1'b0;
	int          burst_left = 0;
	bit          gaps_on = 1'b1;
	int          settings_used = 1;
	logic [11:0] stall_ctr = 12'd0;

	stx_etx_frame_receiver_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk) begin
		stall_ctr <= stall_ctr + 12'd1;
		case (stall_ctr[10:9])
			2'd0: begin
				m_tready <= 1'b1;
			end
			2'd1: begin
				m_tready <= 1'($urandom_range(0, 1));
			end
			2'd2: begin
				m_tready <= (stall_ctr[1:0] == 2'd0);
			end
			default: begin
				m_tready <= ($urandom_range(0, 9) != 0);
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_request(s_tdata, s_tuser);
			end
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tuser, m_tdata);
			end
		end
	end

	function automatic bit is_ctrl(logic [7:0] v);
		return (v == CH_STX) || (v == CH_ETX) || (v == CH_ESC);
	endfunction

	function automatic bit can_escape(logic [7:0] v);
		return !is_ctrl(v + ESC_OFFSET);
	endfunction

	task automatic send(input logic [7:0] b, input logic err);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (gaps_on) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= err;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		requests_sent++;
		if (counting) begin
			counted_requests++;
		end
	endtask

	task automatic send_data(input logic [7:0] v, input bit esc);
		if (esc) begin
			if ($urandom_range(0, 19) == 0) begin
				send(CH_ESC, 1'b0);
			end
			send(CH_ESC, 1'b0);
			send(v + ESC_OFFSET, 1'b0);
		end else begin
			send(v, 1'b0);
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_max_length(input logic [7:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.max_len = v;
		settings_used++;
	endtask

	task automatic random_frame();
		int         n;
		int         r;
		int         choice;
		int         cut;
		int         escs;
		logic [7:0] payload[$];
		bit         esc_flag[$];
		logic [7:0] len;
		logic [7:0] v;
		bit         e;
		choice = $urandom_range(0, 99);
		r = $urandom_range(0, 99);
		if (r < 80) begin
			n = $urandom_range(1, 12);
		end else if (r < 95) begin
			n = $urandom_range(13, 40);
		end else begin
			n = $urandom_range((sb.max_len > 3) ? sb.max_len - 2 : 1, sb.max_len + 3);
		end
		if (choice >= 95) begin
			counting = 1'b0;
			repeat (n) send(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			counting = 1'b1;
			return;
		end
		escs = 0;
		payload.push_back(8'd0);
		esc_flag.push_back(1'b0);
		for (int i = 1; i < n; i++) begin
			v = 8'($urandom_range(0, 255));
			e = is_ctrl(v) || (can_escape(v) && $urandom_range(0, 4) == 0);
			escs += e;
			payload.push_back(v);
			esc_flag.push_back(e);
		end
		len = 8'(n + escs);
		e = 1'b0;
		if (is_ctrl(len) || ($urandom_range(0, 4) == 0 && can_escape(len + 8'd1))) begin
			len = len + 8'd1;
			e = 1'b1;
		end
		if (choice >= 70) begin
			len = 8'($urandom_range(0, 255));
			e = is_ctrl(len) || (can_escape(len) && $urandom_range(0, 1) == 0);
		end
		payload[0] = len;
		esc_flag[0] = e;
		cut = $urandom_range(0, n);
		send(CH_STX, 1'b0);
		if (choice >= 90 && cut == 0) begin
			send(CH_ETX, 1'b0);
			return;
		end
		for (int i = 0; i < n; i++) begin
			if (i == cut && choice >= 80 && choice < 85) begin
				send(8'($urandom_range(0, 255)), 1'b1);
			end
			if (i == cut && choice >= 85 && choice < 90) begin
				send(CH_STX, 1'b0);
			end
			send_data(payload[i], esc_flag[i]);
		end
		if (choice >= 90) begin
			send(CH_ESC, 1'b0);
		end
		send(CH_ETX, 1'b0);
	endtask

	task automatic random_phase(input int quota);
		int target;
		target = counted_requests + quota;
		counting = 1'b1;
		while (counted_requests < target) begin
			random_frame();
			if ($urandom_range(0, 7) == 0) begin
				send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end
		counting = 1'b0;
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 8'd0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'd0;
		s_tuser <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Bytes while hunting are dropped, then an empty frame.
		send(8'h00, 1'b0);
		send(8'hFF, 1'b0);
		send(CH_ETX, 1'b0);
		send(CH_ESC, 1'b1);
		send(CH_STX, 1'b0);
		send(CH_ETX, 1'b0);
		// Good frame whose escaped length byte absorbs the escape count.
		send(CH_STX, 1'b0);
		send(CH_ESC, 1'b0);
		send(8'h83, 1'b0);
		send(8'hFF, 1'b0);
		send(CH_ETX, 1'b0);
		// Restart inside a frame, then a doubled escape.
		send(CH_STX, 1'b0);
		send(8'h00, 1'b0);
		send(CH_STX, 1'b0);
		send(CH_ESC, 1'b0);
		send(CH_ESC, 1'b0);
		send(8'h82, 1'b0);
		send(CH_ETX, 1'b0);
		// Line error mid-frame; the following bytes are ignored.
		send(CH_STX, 1'b0);
		send(8'h05, 1'b0);
		send(8'hAA, 1'b1);
		send(8'h55, 1'b0);
		send(CH_ETX, 1'b0);

		set_max_length(8'd2);
		send(CH_STX, 1'b0);
		send(8'h01, 1'b0);
		send(8'h22, 1'b0);
		send(CH_ETX, 1'b0);

		random_phase(150);
		set_max_length(8'd255);
		random_phase(200);
		gaps_on = 1'b0;
		set_max_length(8'($urandom_range(3, 20)));
		random_phase(150);
		gaps_on = 1'b1;
		set_max_length(8'd100);
		random_phase(100);
		wait_drained();
		random_phase(100);
		set_max_length(8'($urandom_range(2, 255)));
		random_phase(200);
		set_max_length(8'd3);
		random_phase(150);
		gaps_on = 1'b0;
		set_max_length(8'd255);
		random_phase(150);
		gaps_on = 1'b1;
		set_max_length(8'($urandom_range(2, 255)));
		random_phase(200);

		wait_drained();
		repeat (8) @(posedge clk);
		$display("Sent %0d byte requests under %0d max_length settings.",
			requests_sent, settings_used);
		$display("Results: %0d data, %0d good, %0d mismatch, %0d overflow, %0d restart.",
			sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
			sb.kind_seen[4]);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
